// ===== rtl/fwg_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the flash write guard and erase tracker
// no dependencies; imported by every other file of the block except fwg_ram

package fwg_pkg;

	localparam int ADDR_W        = 20;
	localparam int REG_W         = 21;
	localparam int LEN_W         = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int SEGMENT_BYTES = 512;
	localparam int MAX_WRITE_LEN = 128;

	localparam logic [REG_W-1:0] ADDR_SPACE = REG_W'(1) << ADDR_W;

	typedef enum logic [1:0] {
		ACT_ERASE   = 2'd0,
		ACT_PROGRAM = 2'd1,
		ACT_REJECT  = 2'd2
	} fwg_act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_WIN_START    = 3'd0,
		REG_LOW_WIN_END      = 3'd1,
		REG_HIGH_WIN_START   = 3'd2,
		REG_HIGH_WIN_END     = 3'd3,
		REG_BOOT_START       = 3'd4,
		REG_BOOT_END         = 3'd5,
		REG_VECTOR_SEG_START = 3'd6,
		REG_VECTOR_SEG_END   = 3'd7
	} fwg_reg_t;

	typedef struct packed {
		logic [REG_W-1:0] low_win_start;
		logic [REG_W-1:0] low_win_end;
		logic [REG_W-1:0] high_win_start;
		logic [REG_W-1:0] high_win_end;
		logic [REG_W-1:0] boot_start;
		logic [REG_W-1:0] boot_end;
		logic [REG_W-1:0] vector_seg_start;
		logic [REG_W-1:0] vector_seg_end;
	} fwg_cfg_t;

	// classified request handed from front to back
	typedef struct packed {
		logic              is_begin;
		logic              ok;
		logic              two;
		logic              prot0;
		logic              prot1;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] seg0;
		logic [ADDR_W-1:0] seg1;
		logic [ADDR_W-1:0] base0;
		logic [ADDR_W-1:0] base1;
	} fwg_cmd_t;

endpackage

// ===== rtl/fwg_req_if.sv =====
`timescale 1ns / 1ps
// request channel: valid/ready handshake with the input item fields
// depends on fwg_pkg

interface fwg_req_if;
	import fwg_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ADDR_W-1:0] address;
	logic [LEN_W-1:0]  length;

	modport source(output valid, req_type, address, length, input ready);
	modport sink(input valid, req_type, address, length, output ready);
endinterface

// ===== rtl/fwg_res_if.sv =====
`timescale 1ns / 1ps
// result channel: valid/ready handshake with the result item fields
// depends on fwg_pkg

interface fwg_res_if;
	import fwg_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [ADDR_W-1:0] target_address;
	logic              last;

	modport source(output valid, action, target_address, last, input ready);
	modport sink(input valid, action, target_address, last, output ready);
endinterface

// ===== rtl/fwg_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module fwg_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/fwg_front.sv =====
`timescale 1ns / 1ps
// front part: takes a request, runs the window, length and protection checks
// and the segment split, then hands a classified command to the queue; uses fwg_pkg

module fwg_front (
	input  logic             clk,
	input  logic             arst_n,
	input  fwg_pkg::fwg_cfg_t cfg,
	fwg_req_if.sink          req,
	output logic             push_valid,
	input  logic             push_ready,
	output fwg_pkg::fwg_cmd_t push_data
);
	import fwg_pkg::*;

	// exact floor division by the segment size through a reciprocal
	localparam int SB_LOG  = $clog2(SEGMENT_BYTES);
	localparam int SHIFT   = ADDR_W + SB_LOG;
	localparam int RECIP_W = ADDR_W + 1;
	localparam int PROD_W  = ADDR_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << SHIFT)
		+ 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES));

	typedef enum logic [1:0] {F_IDLE, F_CHECK, F_SEG, F_PROT} fstate_t;

	fstate_t           state_q;
	logic              is_write_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [REG_W-1:0]  end_q;
	logic              allowed_s2;
	logic [ADDR_W-1:0] seg0_s2;
	logic [ADDR_W-1:0] seg1_s2;
	logic              ok_s3;
	logic              two_s3;
	logic [ADDR_W-1:0] base0_s3;
	logic [ADDR_W-1:0] base1_s3;

	logic              allowed;
	logic [ADDR_W-1:0] end_m1;
	logic [PROD_W-1:0] prod0;
	logic [PROD_W-1:0] prod1;
	logic [ADDR_W-1:0] span;
	logic              prot0;
	logic              prot1;

	function automatic logic touches(input fwg_cfg_t c, input logic [REG_W-1:0] a0,
		input logic [REG_W-1:0] a1);
		touches = ((a0 < c.boot_end) && (a1 > c.boot_start))
			|| ((a0 < c.vector_seg_end) && (a1 > c.vector_seg_start));
	endfunction

	assign req.ready = (state_q == F_IDLE);

	always_comb begin
		logic             len_ok;
		logic             in_low;
		logic             in_high;
		logic [REG_W-1:0] a21;
		a21     = {1'b0, addr_q};
		len_ok  = (len_q != '0) && (len_q <= LEN_W'(MAX_WRITE_LEN));
		in_low  = (a21 >= cfg.low_win_start) && (end_q <= cfg.low_win_end);
		in_high = (a21 >= cfg.high_win_start) && (end_q <= cfg.high_win_end);
		allowed = len_ok && (end_q <= ADDR_SPACE) && (in_low || in_high)
			&& !touches(cfg, a21, end_q);
		end_m1  = ADDR_W'(end_q - REG_W'(1));
		prod0   = PROD_W'(addr_q) * PROD_W'(RECIP);
		prod1   = PROD_W'(end_m1) * PROD_W'(RECIP);
		span    = seg1_s2 - seg0_s2;
		prot0   = touches(cfg, {1'b0, base0_s3}, {1'b0, base0_s3} + REG_W'(SEGMENT_BYTES));
		prot1   = touches(cfg, {1'b0, base1_s3}, {1'b0, base1_s3} + REG_W'(SEGMENT_BYTES));
	end

	assign push_valid      = (state_q == F_PROT);
	assign push_data.is_begin = !is_write_q;
	assign push_data.ok    = ok_s3;
	assign push_data.two   = two_s3;
	assign push_data.prot0 = prot0;
	assign push_data.prot1 = prot1;
	assign push_data.addr  = addr_q;
	assign push_data.seg0  = seg0_s2;
	assign push_data.seg1  = seg1_s2;
	assign push_data.base0 = base0_s3;
	assign push_data.base1 = base1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			is_write_q <= 1'b0;
			addr_q     <= '0;
			len_q      <= '0;
			end_q      <= '0;
			allowed_s2 <= 1'b0;
			seg0_s2    <= '0;
			seg1_s2    <= '0;
			ok_s3      <= 1'b0;
			two_s3     <= 1'b0;
			base0_s3   <= '0;
			base1_s3   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (req.valid) begin
						is_write_q <= req.req_type;
						addr_q     <= req.address;
						len_q      <= req.length;
						end_q      <= {1'b0, req.address} + REG_W'(req.length);
						state_q    <= F_CHECK;
					end
				end
				F_CHECK: begin
					allowed_s2 <= allowed;
					seg0_s2    <= ADDR_W'(prod0 >> SHIFT);
					seg1_s2    <= ADDR_W'(prod1 >> SHIFT);
					state_q    <= F_SEG;
				end
				F_SEG: begin
					ok_s3    <= allowed_s2 && (span <= ADDR_W'(1));
					two_s3   <= (seg1_s2 != seg0_s2);
					base0_s3 <= ADDR_W'(seg0_s2 * ADDR_W'(SEGMENT_BYTES));
					base1_s3 <= ADDR_W'(seg1_s2 * ADDR_W'(SEGMENT_BYTES));
					state_q  <= F_PROT;
				end
				F_PROT: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/fwg_queue.sv =====
`timescale 1ns / 1ps
// two-entry command queue between front and back
// depends on fwg_pkg

module fwg_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  fwg_pkg::fwg_cmd_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output fwg_pkg::fwg_cmd_t pop_data
);
	import fwg_pkg::*;

	localparam int DEPTH = 2;
	localparam int CNT_W = $clog2(DEPTH+1);

	fwg_cmd_t                   mem_q [DEPTH];
	logic [$clog2(DEPTH)-1:0]   wr_ptr_q;
	logic [$clog2(DEPTH)-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]           count_q;
	logic                       push;
	logic                       pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== rtl/fwg_back.sv =====
`timescale 1ns / 1ps
// back part: looks up the erased map, issues erase, program and reject
// transfers, and sweeps the map clear; uses fwg_pkg, fwg_ram, fwg_res_if

module fwg_back #(
	parameter int SEGMENT_COUNT = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  fwg_pkg::fwg_cmd_t pop_data,
	fwg_res_if.source         res
);
	import fwg_pkg::*;

	localparam int IDX_W = $clog2(SEGMENT_COUNT);

	typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_EVAL, B_FINAL} bstate_t;

	bstate_t           state_q;
	fwg_cmd_t          cur_q;
	logic              sel_q;
	logic [IDX_W-1:0]  clr_q;
	fwg_act_t          fin_act_q;
	logic              res_valid_q;
	fwg_act_t          act_q;
	logic [ADDR_W-1:0] tgt_q;
	logic              last_q;

	logic [ADDR_W-1:0] seg_sel;
	logic [ADDR_W-1:0] base_sel;
	logic              prot_sel;
	logic              in_map;
	logic              rd_bit;
	logic              marked;
	logic              out_free;
	logic              final_seg;
	logic              clearing;
	logic              mark_we;

	assign seg_sel   = sel_q ? cur_q.seg1 : cur_q.seg0;
	assign base_sel  = sel_q ? cur_q.base1 : cur_q.base0;
	assign prot_sel  = sel_q ? cur_q.prot1 : cur_q.prot0;
	assign in_map    = (seg_sel < ADDR_W'(SEGMENT_COUNT));
	assign marked    = in_map && rd_bit;
	assign out_free  = !res_valid_q || res.ready;
	assign final_seg = !(cur_q.two && !sel_q);
	assign clearing  = (state_q == B_CLEAR);
	assign mark_we   = (state_q == B_EVAL) && !marked && out_free && !prot_sel && in_map;
	assign pop_ready = (state_q == B_IDLE);

	fwg_ram #(
		.WIDTH(1),
		.DEPTH(SEGMENT_COUNT)
	) u_map (
		.clk  (clk),
		.we   (clearing || mark_we),
		.waddr(clearing ? clr_q : seg_sel[IDX_W-1:0]),
		.wdata(!clearing),
		.re   (state_q == B_READ),
		.raddr(seg_sel[IDX_W-1:0]),
		.rdata(rd_bit)
	);

	assign res.valid          = res_valid_q;
	assign res.action         = act_q;
	assign res.target_address = tgt_q;
	assign res.last           = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			cur_q       <= '0;
			sel_q       <= 1'b0;
			clr_q       <= '0;
			fin_act_q   <= ACT_PROGRAM;
			res_valid_q <= 1'b0;
			act_q       <= ACT_PROGRAM;
			tgt_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(SEGMENT_COUNT - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop_valid) begin
						cur_q <= pop_data;
						sel_q <= 1'b0;
						if (pop_data.is_begin) begin
							clr_q   <= '0;
							state_q <= B_CLEAR;
						end else if (!pop_data.ok) begin
							fin_act_q <= ACT_REJECT;
							state_q   <= B_FINAL;
						end else begin
							state_q <= B_READ;
						end
					end
				end
				B_READ: state_q <= B_EVAL;
				B_EVAL: begin
					if (marked) begin
						if (!final_seg) begin
							sel_q   <= 1'b1;
							state_q <= B_READ;
						end else begin
							fin_act_q <= ACT_PROGRAM;
							state_q   <= B_FINAL;
						end
					end else if (out_free) begin
						res_valid_q <= 1'b1;
						if (prot_sel) begin
							act_q   <= ACT_REJECT;
							tgt_q   <= cur_q.addr;
							last_q  <= 1'b1;
							state_q <= B_IDLE;
						end else begin
							act_q  <= ACT_ERASE;
							tgt_q  <= base_sel;
							last_q <= 1'b0;
							if (!final_seg) begin
								sel_q   <= 1'b1;
								state_q <= B_READ;
							end else begin
								fin_act_q <= ACT_PROGRAM;
								state_q   <= B_FINAL;
							end
						end
					end
				end
				B_FINAL: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						act_q       <= fin_act_q;
						tgt_q       <= cur_q.addr;
						last_q      <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/flash_write_guard_erase_tracker_top.sv =====
`timescale 1ns / 1ps
// top level of the flash write guard and erase tracker: config registers,
// front, queue and back; depends on fwg_pkg, fwg_req_if, fwg_res_if and submodules
//
//   channel  | direction | handshake        | payload
//   req      | in        | valid / ready    | req_type, address, length
//   res      | out       | valid / ready    | action, target_address, last
//   cfg      | in        | cfg_we only      | cfg_index, cfg_data
//
// the front takes a request only while idle and finishes it before it takes the next
// (accept, check, segment split, protection check and push into a two-entry queue)
// the back takes a command from the queue while idle, then looks up each segment
// in the erased map through a read state and an evaluate state, then sends the final transfer
// a begin session sweeps the whole erased map clear; the same sweep runs after reset,
// and requests queue up behind it
// either side stalls on its own: the result register frees the back, the queue frees the front

module flash_write_guard_erase_tracker_top #(
	parameter int SEGMENT_COUNT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fwg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fwg_pkg::REG_W-1:0]       cfg_data,
	fwg_req_if.sink                         req,
	fwg_res_if.source                       res
);
	import fwg_pkg::*;

	fwg_cfg_t cfg_q;
	logic     push_valid;
	logic     push_ready;
	fwg_cmd_t push_data;
	logic     pop_valid;
	logic     pop_ready;
	fwg_cmd_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (fwg_reg_t'(cfg_index))
				REG_LOW_WIN_START:    cfg_q.low_win_start    <= cfg_data;
				REG_LOW_WIN_END:      cfg_q.low_win_end      <= cfg_data;
				REG_HIGH_WIN_START:   cfg_q.high_win_start   <= cfg_data;
				REG_HIGH_WIN_END:     cfg_q.high_win_end     <= cfg_data;
				REG_BOOT_START:       cfg_q.boot_start       <= cfg_data;
				REG_BOOT_END:         cfg_q.boot_end         <= cfg_data;
				REG_VECTOR_SEG_START: cfg_q.vector_seg_start <= cfg_data;
				REG_VECTOR_SEG_END:   cfg_q.vector_seg_end   <= cfg_data;
			endcase
		end
	end

	fwg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	fwg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	fwg_back #(
		.SEGMENT_COUNT(SEGMENT_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.res      (res)
	);

`ifndef SYNTHESIS
	a_not_last_is_erase: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.last |-> res.action == ACT_ERASE)
		else $error("non-final result is not an erase");

	a_erase_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.action == ACT_ERASE |-> !res.last)
		else $error("erase marked as final result");

	a_one_item_in_front: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("front took a request while busy");
`endif
endmodule
